@@ rtl/hmts_pkg.sv @@
`timescale 1ns / 1ps

package hmts_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int POS_W     = 16;
    localparam int INT_W     = POS_W - FRAC_BITS;
    localparam int CELL_W    = 8;
    localparam int SCALE_W   = 16;
    localparam int SAMPLE_W  = 8;
    localparam int HEIGHT_W  = 24;
    localparam int OP_W      = 16;
    localparam int ACC_W     = 2 * OP_W;
    localparam int BASE_W    = 18;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_WIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DEEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

    localparam logic [CELL_W-1:0]  RST_CELLS_WIDE   = 8'd255;
    localparam logic [CELL_W-1:0]  RST_CELLS_DEEP   = 8'd255;
    localparam logic [SCALE_W-1:0] RST_HEIGHT_SCALE = 16'd26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_ADDR,
        ST_MAC,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              en;
        logic              clr;
        logic [OP_W-1:0]   a;
        logic [OP_W-1:0]   b;
        logic [ACC_W-1:0]  addend;
    } t_mac_op;

    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [BASE_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_grid_req;

endpackage

@@ rtl/heightmap_triangle_height_sample.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Words           tdata (low bit up)                  tuser
// s_axis    in   write / query   pos_x[15:0] pos_z[31:16] sample[39:32]  cmd
// m_axis    out  one per query   terrain_height[23:0]                outside
// cfg       in   register write  i_cfg_idx selects, i_cfg_data value  -
//
// Write: not ready again until BASE and ADDR are done. Query: result registered after
// BASE, ADDR, MAC, SCALE (4 grid reads through one single-port memory feeding one
// shared multiply-accumulate unit, then one scale pass); outside query: BASE, ADDR.
// Synchronous active-low reset clears control, presets config; grid is not cleared.
// A held result does not block the next accept; a new result waits for it.
module heightmap_triangle_height_sample #(
    parameter int MAX_VERTS_PER_SIDE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hmts_pkg::S_DATA_W-1:0] s_axis_tdata,   // pos_x, pos_z, sample
    input  logic                          s_axis_tuser,   // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hmts_pkg::M_DATA_W-1:0] m_axis_tdata,   // terrain_height
    output logic                          m_axis_tuser,   // outside
    input  logic                          i_cfg_we,
    input  logic [hmts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hmts_pkg::CFG_W-1:0]    i_cfg_data
);
    import hmts_pkg::*;

    localparam int GRID_DEPTH = MAX_VERTS_PER_SIDE * MAX_VERTS_PER_SIDE;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [INT_W-1:0]    r_x, r_z;
    logic [FRAC_BITS-1:0] r_fx, r_fz;
    logic [SAMPLE_W-1:0] r_sample;
    logic [BASE_W-1:0]   r_base;
    logic [1:0]          r_k;
    logic                r_outside;
    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_out_height;
    logic                r_out_flag;
    logic [CELL_W-1:0]   r_cells_wide, r_cells_deep;
    logic [SCALE_W-1:0]  r_height_scale;

    t_mac_op             w_mac_op;
    logic [ACC_W-1:0]    w_acc;
    t_grid_req           w_grid_req;
    logic [SAMPLE_W-1:0] w_rdata;

    logic                w_accept;
    logic                w_out_free;
    logic [CELL_W:0]     w_stride;
    logic [BASE_W-1:0]   w_base_now;
    logic                w_outside_now;
    logic                w_wr_ok;
    logic [WGT_W-1:0]    w_sum;
    logic                w_lower;
    logic [WGT_W-1:0]    w_weight;
    logic [1:0]          w_k_next;
    logic [BASE_W-1:0]   w_offset;

    hmts_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_mac_op),
        .o_acc (w_acc)
    );

    hmts_grid #(
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_req   (w_grid_req),
        .o_rdata (w_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_stride      = {1'b0, r_cells_wide} + (CELL_W + 1)'(1);
    assign w_base_now    = w_acc[BASE_W-1:0];
    assign w_outside_now = (r_x >= r_cells_wide) || (r_z >= r_cells_deep);
    assign w_wr_ok       = (r_x <= r_cells_wide) && (r_z <= r_cells_deep);

    assign w_sum   = WGT_W'(r_fx) + WGT_W'(r_fz);
    assign w_lower = w_sum <= WGT_W'(ONE);
    assign w_k_next = r_k + 2'd1;

    // corner order: (x,z) (x,z+1) (x+1,z) (x+1,z+1)
    always_comb begin
        w_weight = '0;
        case (r_k)
            2'd0: w_weight = w_lower ? WGT_W'(ONE) - w_sum : '0;
            2'd1: w_weight = w_lower ? WGT_W'(r_fz) : WGT_W'(ONE) - WGT_W'(r_fx);
            2'd2: w_weight = w_lower ? WGT_W'(r_fx) : WGT_W'(ONE) - WGT_W'(r_fz);
            2'd3: w_weight = w_lower ? '0 : w_sum - WGT_W'(ONE);
            default: w_weight = '0;
        endcase
    end

    always_comb begin
        w_offset = '0;
        case (w_k_next)
            2'd1: w_offset = BASE_W'(w_stride);
            2'd2: w_offset = BASE_W'(1);
            2'd3: w_offset = BASE_W'(w_stride) + BASE_W'(1);
            default: w_offset = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_BASE;
            end
            ST_BASE: n_state = ST_ADDR;
            ST_ADDR: begin
                if (r_cmd == CMD_WRITE) n_state = ST_IDLE;
                else if (w_outside_now) n_state = ST_DONE;
                else n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_k == 2'd3) n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mac_op   = '0;
        w_grid_req = '0;
        case (r_state)
            ST_BASE: begin
                w_mac_op.en     = 1'b1;
                w_mac_op.clr    = 1'b1;
                w_mac_op.a      = OP_W'(w_stride);
                w_mac_op.b      = OP_W'(r_z);
                w_mac_op.addend = ACC_W'(r_x);
            end
            ST_ADDR: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = 1'b1;
                if (r_cmd == CMD_WRITE) begin
                    w_grid_req.wr   = w_wr_ok;
                    w_grid_req.addr = w_base_now;
                    w_grid_req.data = r_sample;
                end else begin
                    w_grid_req.rd   = !w_outside_now;
                    w_grid_req.addr = w_base_now;
                end
            end
            ST_MAC: begin
                w_mac_op.en     = 1'b1;
                w_mac_op.a      = OP_W'(w_weight);
                w_mac_op.b      = OP_W'(w_rdata);
                w_grid_req.rd   = (r_k != 2'd3);
                w_grid_req.addr = r_base + w_offset;
            end
            ST_SCALE: begin
                w_mac_op.en  = 1'b1;
                w_mac_op.clr = 1'b1;
                w_mac_op.a   = w_acc[OP_W-1:0];
                w_mac_op.b   = r_height_scale;
            end
            default: begin
                w_mac_op   = '0;
                w_grid_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_k            <= '0;
            r_out_valid    <= 1'b0;
            r_cells_wide   <= RST_CELLS_WIDE;
            r_cells_deep   <= RST_CELLS_DEEP;
            r_height_scale <= RST_HEIGHT_SCALE;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CELLS_WIDE:   r_cells_wide   <= i_cfg_data[CELL_W-1:0];
                    REG_CELLS_DEEP:   r_cells_deep   <= i_cfg_data[CELL_W-1:0];
                    REG_HEIGHT_SCALE: r_height_scale <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_ADDR) r_k <= '0;
            if (r_state == ST_MAC) r_k <= w_k_next;
            if (r_state == ST_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_fx     <= s_axis_tdata[FRAC_BITS-1:0];
            r_x      <= s_axis_tdata[POS_W-1:FRAC_BITS];
            r_fz     <= s_axis_tdata[POS_W+FRAC_BITS-1:POS_W];
            r_z      <= s_axis_tdata[2*POS_W-1:POS_W+FRAC_BITS];
            r_sample <= s_axis_tdata[2*POS_W+SAMPLE_W-1:2*POS_W];
        end
        if (r_state == ST_ADDR) begin
            r_base    <= w_base_now;
            r_outside <= w_outside_now;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_height <= r_outside ? '0 : w_acc[FRAC_BITS +: HEIGHT_W];
            r_out_flag   <= r_outside;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_height;
    assign m_axis_tuser  = r_out_flag;

endmodule

@@ rtl/hmts_mac.sv @@
`timescale 1ns / 1ps

module hmts_mac (
    input  logic                       i_clk,
    input  hmts_pkg::t_mac_op          i_op,
    output logic [hmts_pkg::ACC_W-1:0] o_acc
);
    import hmts_pkg::*;

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  w_base;
    logic [2*OP_W-1:0] w_prod;

    assign w_prod = i_op.a * i_op.b;
    assign w_base = i_op.clr ? i_op.addend : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= w_base + ACC_W'(w_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/hmts_grid.sv @@
`timescale 1ns / 1ps

module hmts_grid #(
    parameter int DEPTH = 65536
) (
    input  logic                          i_clk,
    input  hmts_pkg::t_grid_req           i_req,
    output logic [hmts_pkg::SAMPLE_W-1:0] o_rdata
);
    import hmts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_q;
    logic                r_hit;
    logic [31:0]         w_addr_ext;
    logic                w_in_range;

    assign w_addr_ext = 32'(i_req.addr);
    assign w_in_range = w_addr_ext < 32'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_req.wr && w_in_range) begin
            r_mem[w_addr_ext[AW-1:0]] <= i_req.data;
        end
        if (i_req.rd) begin
            r_q   <= r_mem[w_addr_ext[AW-1:0]];
            r_hit <= w_in_range;
        end
    end

    // beyond the store reads as zero
    assign o_rdata = r_hit ? r_q : '0;

endmodule

@@ rtl/hmts_chk.sv @@
`timescale 1ns / 1ps

module hmts_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [hmts_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hmts_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          i_cfg_we,
    input logic [hmts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [hmts_pkg::CFG_W-1:0]    i_cfg_data
);
    import hmts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("outside result with nonzero height");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE) && !m_axis_tvalid
            |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("write produced a result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind heightmap_triangle_height_sample hmts_chk u_hmts_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import hmts_pkg::*;

    localparam int GRID_DEPTH  = 65536;
    localparam int PHASE_WORDS = 190;
    localparam int STALL_LEN   = 300;
    localparam int WATCHDOG    = 3000;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                outside;
    } height_t;

    typedef struct packed {
        t_cmd                cmd;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_z;
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        logic [HEIGHT_W-1:0] typed_height;
        logic                typed_outside;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;   // pos_x, pos_z, sample
    logic                 s_axis_tuser = 1'b0; // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;        // terrain_height
    logic                 m_axis_tuser;        // outside
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    heightmap_triangle_height_sample uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow of the block: grid contents, which entries hold a value, registers
    logic [SAMPLE_W-1:0] grid_shadow [0:GRID_DEPTH-1];
    bit                  grid_set    [0:GRID_DEPTH-1];
    int unsigned         cfg_wide  = RST_CELLS_WIDE;
    int unsigned         cfg_deep  = RST_CELLS_DEEP;
    int unsigned         cfg_scale = RST_HEIGHT_SCALE;

    height_t expected_heights[$];

    int words_sent      = 0;
    int heights_checked = 0;
    int outside_seen    = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;
    int send_idle_pct   = 15;
    int recv_idle_pct   = 69;
    int stall_left      = 0;
    bit stall_req       = 1'b0;

    stim_row_t dir_rows [0:20] = '{
        '{CMD_QUERY, 16'hFFFF, 16'h0000, 8'h00, 1'b1, 24'd0,    1'b1},
        '{CMD_QUERY, 16'h0000, 16'hFFFF, 8'hFF, 1'b1, 24'd0,    1'b1},
        '{CMD_QUERY, 16'hFF80, 16'hFF80, 8'h00, 1'b1, 24'd0,    1'b1},
        '{CMD_WRITE, 16'h0000, 16'h0000, 8'hFF, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'h0100, 16'h0000, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'h0000, 16'h0100, 8'h80, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'h01FF, 16'h01FF, 8'h4D, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0000, 8'h00, 1'b1, 24'd6630, 1'b0},
        '{CMD_QUERY, 16'h0080, 16'h0080, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h0081, 16'h0080, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h00FF, 16'h00FF, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h00FF, 16'h0000, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h0000, 16'h00FF, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'hFE00, 16'hFE00, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'hFF00, 16'hFE00, 8'hFF, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'hFE00, 16'hFF00, 8'hFF, 1'b0, 24'd0,    1'b0},
        '{CMD_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'hFEFF, 16'hFEFF, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'hFE00, 16'hFE00, 8'h00, 1'b1, 24'd0,    1'b0},
        '{CMD_WRITE, 16'h0000, 16'h0000, 8'h00, 1'b0, 24'd0,    1'b0},
        '{CMD_QUERY, 16'h0000, 16'h0000, 8'h00, 1'b1, 24'd0,    1'b0}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic height_t interp_height(input logic [POS_W-1:0] px,
                                              input logic [POS_W-1:0] pz);
        height_t           res;
        int unsigned       xi, zi, fx, fz, stride, base;
        longint unsigned   h0, h1, h2, h3, raw, scaled;
        xi = px >> FRAC_BITS;
        zi = pz >> FRAC_BITS;
        fx = px & (ONE - 1);
        fz = pz & (ONE - 1);
        res.height  = '0;
        res.outside = 1'b1;
        if (xi >= cfg_wide || zi >= cfg_deep)
            return res;
        stride = cfg_wide + 1;
        base   = stride * zi + xi;
        h0 = grid_shadow[base];
        h1 = grid_shadow[base + stride];
        h2 = grid_shadow[base + 1];
        h3 = grid_shadow[base + stride + 1];
        if (fx + fz <= ONE)
            raw = h0 * (ONE - fx - fz) + h2 * fx + h1 * fz;
        else
            raw = h3 * (fx + fz - ONE) + h1 * (ONE - fx) + h2 * (ONE - fz);
        scaled = (raw * cfg_scale) >> FRAC_BITS;
        if (scaled > 64'hFF_FFFF)
            scaled = 64'hFF_FFFF;
        res.height  = scaled[HEIGHT_W-1:0];
        res.outside = 1'b0;
        return res;
    endfunction

    // runs at the accept edge of each word
    task automatic apply_word(input t_cmd cmd, input logic [POS_W-1:0] px,
                              input logic [POS_W-1:0] pz, input logic [SAMPLE_W-1:0] smp,
                              input logic typed, input height_t typed_res);
        int unsigned xi, zi, addr;
        xi = px >> FRAC_BITS;
        zi = pz >> FRAC_BITS;
        if (cmd == CMD_WRITE) begin
            if (xi <= cfg_wide && zi <= cfg_deep) begin
                addr = (cfg_wide + 1) * zi + xi;
                if (addr < GRID_DEPTH) begin
                    grid_shadow[addr] = smp;
                    grid_set[addr]    = 1'b1;
                end
            end
        end else if (typed) begin
            expected_heights.push_back(typed_res);
        end else begin
            expected_heights.push_back(interp_height(px, pz));
        end
    endtask

    task automatic send_word(input t_cmd cmd, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] pz, input logic [SAMPLE_W-1:0] smp,
                             input logic typed = 1'b0, input height_t typed_res = '0);
        if (words_sent < 320) begin
            send_idle_pct = 15;
            recv_idle_pct = 69;
        end else if (words_sent < 640) begin
            send_idle_pct = 69;
            recv_idle_pct = 15;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        @(negedge i_clk);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {smp, pz, px};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        apply_word(cmd, px, pz, smp, typed, typed_res);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_heights.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CELLS_WIDE:   cfg_wide  = val & 8'hFF;
            REG_CELLS_DEEP:   cfg_deep  = val & 8'hFF;
            REG_HEIGHT_SCALE: cfg_scale = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int unsigned wide, input int unsigned deep,
                            input int unsigned scale);
        set_reg(REG_CELLS_WIDE, wide);
        set_reg(REG_CELLS_DEEP, deep);
        set_reg(REG_HEIGHT_SCALE, scale);
    endtask

    // mostly queries on cells whose corners get written first
    task automatic random_phase(input int n_words);
        int          stop_at, pick, cx, cz, kx, kz;
        int unsigned stride, addr;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                cx = $urandom_range(cfg_wide - 1, 0);
                cz = $urandom_range(cfg_deep - 1, 0);
                stride = cfg_wide + 1;
                for (int k = 0; k < 4; k++) begin
                    kx = cx + (k & 1);
                    kz = cz + (k >> 1);
                    addr = stride * kz + kx;
                    if (!grid_set[addr])
                        send_word(CMD_WRITE, {kx[7:0], 8'($urandom)},
                                  {kz[7:0], 8'($urandom)}, 8'($urandom));
                end
                send_word(CMD_QUERY, {cx[7:0], 8'($urandom)},
                          {cz[7:0], 8'($urandom)}, 8'($urandom));
            end else if (pick < 70) begin
                if ($urandom_range(1, 0)) begin
                    cx = $urandom_range(255, cfg_wide);
                    cz = $urandom_range(255, 0);
                end else begin
                    cx = $urandom_range(255, 0);
                    cz = $urandom_range(255, cfg_deep);
                end
                send_word(CMD_QUERY, {cx[7:0], 8'($urandom)},
                          {cz[7:0], 8'($urandom)}, 8'($urandom));
            end else if (pick < 90) begin
                cx = $urandom_range(cfg_wide, 0);
                cz = $urandom_range(cfg_deep, 0);
                send_word(CMD_WRITE, {cx[7:0], 8'($urandom)},
                          {cz[7:0], 8'($urandom)}, 8'($urandom));
            end else begin
                send_word(CMD_WRITE, 16'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_left = STALL_LEN;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        height_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_heights.size() == 0) begin
                $error("unexpected result word: terrain_height %0d outside %0d",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_heights.pop_front();
                heights_checked++;
                if (want.outside)
                    outside_seen++;
                if (m_axis_tdata !== want.height) begin
                    $error("terrain_height mismatch: expected %0d, got %0d",
                           want.height, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.outside) begin
                    $error("outside mismatch: expected %0d, got %0d",
                           want.outside, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench: timeout, %0d results outstanding",
                     expected_heights.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].pos_x, dir_rows[i].pos_z,
                      dir_rows[i].sample, dir_rows[i].typed,
                      height_t'{dir_rows[i].typed_height, dir_rows[i].typed_outside});
        random_phase(PHASE_WORDS);

        set_grid(1, 1, 16'hFFFF);
        stall_req = 1'b1;
        random_phase(PHASE_WORDS);

        set_grid(255, 2, 0);
        random_phase(PHASE_WORDS);

        set_grid(3, 255, 256);
        random_phase(PHASE_WORDS);

        set_grid($urandom_range(255, 1), $urandom_range(255, 1), $urandom_range(65535, 0));
        stall_req = 1'b1;
        random_phase(PHASE_WORDS);

        drain();
        repeat (20) @(posedge i_clk);

        $display("testbench: %0d words sent over 5 grid settings, %0d heights checked",
                 words_sent, heights_checked);
        $display("testbench: %0d outside queries, %0d mismatches", outside_seen, mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/hmts_pkg.sv
rtl/hmts_mac.sv
rtl/hmts_grid.sv
rtl/heightmap_triangle_height_sample.sv
rtl/hmts_chk.sv
tb/testbench.sv
